FILE: src/stereo_median_click_repair_macros.svh
// Assertion macros shared by the click repair RTL.
`ifndef STEREO_MEDIAN_CLICK_REPAIR_MACROS_SVH
`define STEREO_MEDIAN_CLICK_REPAIR_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted (reset active low)
`define SMCR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// Clocked check that also holds during reset
`define SMCR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SMCR_ASSERT(label, clk, rst_n, prop, msg)
`define SMCR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: src/smcr_pkg.sv
// Shared types and constants for the stereo median click repair block.
package smcr_pkg;

    // Q1.16 fraction registers
    localparam int          FRAC_W   = 17;
    localparam logic [16:0] FRAC_ONE = 17'h10000;

    // Window register width
    localparam int WIN_REG_W = 4;

    // Configuration register indexes
    localparam int          CFG_ADDR_W    = 2;
    localparam logic [1:0]  CFG_THRESHOLD = 2'd0;
    localparam logic [1:0]  CFG_REPAIR    = 2'd1;
    localparam logic [1:0]  CFG_WINDOW    = 2'd2;
    localparam logic [1:0]  CFG_MIX       = 2'd3;

    // Register reset values
    localparam logic [16:0] RST_THRESHOLD = 17'd19661;
    localparam logic [16:0] RST_REPAIR    = 17'd45875;
    localparam logic [3:0]  RST_WINDOW    = 4'd5;
    localparam logic [16:0] RST_MIX       = 17'd65536;

    typedef struct packed {
        logic [FRAC_W-1:0]    threshold_knob;
        logic [FRAC_W-1:0]    repair_amount;
        logic [WIN_REG_W-1:0] window_length;
        logic [FRAC_W-1:0]    wet_mix;
    } t_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;   // input transfer: write history, capture sample
        logic scan;      // test one median candidate
        logic rep;       // deviation test and repair product
        logic mix;       // wet/dry product
        logic out_load;  // load output register
        logic busy;      // item in flight
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last; // current candidate is the last one in the window
    } t_stat;

endpackage

FILE: src/smcr_ctrl.sv
// Sequencing state machine for the click repair block.
`include "stereo_median_click_repair_macros.svh"

module smcr_ctrl import smcr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_REP  = 3'd2;
    localparam logic [2:0] ST_MIX  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       in_fire;
    logic       out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_stat.scan_last) n_state = ST_REP;
            end
            ST_REP:  n_state = ST_MIX;
            ST_MIX:  n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd.load_in  = in_fire;
        o_cmd.scan     = (r_state == ST_SCAN);
        o_cmd.rep      = (r_state == ST_REP);
        o_cmd.mix      = (r_state == ST_MIX);
        o_cmd.out_load = (r_state == ST_DONE) && out_free;
        o_cmd.busy     = (r_state != ST_IDLE);
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `SMCR_ASSERT(a_accept_starts_scan, i_clk, i_rst_n, in_fire |=> (r_state == ST_SCAN), "accepted item did not start the median scan")
    `SMCR_ASSERT(a_scan_ends, i_clk, i_rst_n, ((r_state == ST_SCAN) && i_stat.scan_last) |=> (r_state == ST_REP), "median scan did not end on last candidate")
    `SMCR_ASSERT(a_done_shows_result, i_clk, i_rst_n, o_cmd.out_load |=> ((r_state == ST_IDLE) && r_out_valid), "loaded result not presented")

endmodule

FILE: src/smcr_lane.sv
// One channel: sample history, median scan, repair and wet/dry blend.
module smcr_lane import smcr_pkg::*; #(
    parameter int MAX_WINDOW  = 9,
    parameter int SAMPLE_BITS = 24,
    parameter int POS_W       = 4,
    parameter int IDX_W       = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [POS_W-1:0]              i_wr_pos,
    input  logic [IDX_W-1:0]              i_cand,
    input  logic [POS_W-1:0]              i_win,
    input  logic [SAMPLE_BITS-1:0]        i_limit,
    input  logic [FRAC_W-1:0]             i_rep,
    input  logic [FRAC_W-1:0]             i_mix,
    output logic signed [SAMPLE_BITS-1:0] o_result
);

    localparam int PW = SAMPLE_BITS + 19;

    logic signed [SAMPLE_BITS-1:0] r_hist [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_med;
    logic signed [SAMPLE_BITS:0]   r_pull;
    logic signed [SAMPLE_BITS:0]   r_q;
    logic signed [SAMPLE_BITS-1:0] r_res;

    logic signed [SAMPLE_BITS-1:0] cand;
    logic [POS_W-1:0]              lt_cnt;
    logic [POS_W-1:0]              le_cnt;
    logic [POS_W-1:0]              half_win;
    logic                          hit;
    logic signed [SAMPLE_BITS:0]   dev;
    logic [SAMPLE_BITS:0]          dev_abs;
    logic                          flagged;
    logic signed [PW-1:0]          rep_prod;
    logic signed [PW-1:0]          rep_sh;
    logic signed [PW-1:0]          mix_prod;
    logic signed [PW-1:0]          mix_sh;
    logic signed [SAMPLE_BITS:0]   out_sum;

    // History ring, written at the shared position on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WINDOW; i++) r_hist[i] <= '0;
        end else if (i_cmd.load_in) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                if (i_wr_pos == POS_W'(i)) r_hist[i] <= i_sample;
            end
        end
    end

    // Rank of the current candidate within the window
    assign cand     = r_hist[i_cand];
    assign half_win = i_win >> 1;

    always_comb begin
        lt_cnt = '0;
        le_cnt = '0;
        for (int j = 0; j < MAX_WINDOW; j++) begin
            if (POS_W'(j) < i_win) begin
                if (r_hist[j] < cand)  lt_cnt = lt_cnt + POS_W'(1);
                if (r_hist[j] <= cand) le_cnt = le_cnt + POS_W'(1);
            end
        end
    end

    // Candidate is the median when it straddles the middle rank
    assign hit = (lt_cnt <= half_win) && (le_cnt > half_win);

    // Deviation from median and repair pull
    assign dev      = (SAMPLE_BITS+1)'(r_med) - (SAMPLE_BITS+1)'(r_x);
    assign dev_abs  = dev[SAMPLE_BITS] ? unsigned'(-dev) : unsigned'(dev);
    assign flagged  = dev_abs > (SAMPLE_BITS+1)'(i_limit);
    assign rep_prod = PW'(dev) * PW'(signed'({1'b0, i_rep}));
    assign rep_sh   = rep_prod >>> 16;

    // Wet/dry blend of the pull
    assign mix_prod = PW'(r_pull) * PW'(signed'({1'b0, i_mix}));
    assign mix_sh   = mix_prod >>> 16;
    assign out_sum  = (SAMPLE_BITS+1)'(r_x) + r_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) r_x <= i_sample;
        if (i_cmd.scan && hit) r_med <= cand;
        if (i_cmd.rep) r_pull <= flagged ? rep_sh[SAMPLE_BITS:0] : '0;
        if (i_cmd.mix) r_q <= mix_sh[SAMPLE_BITS:0];
        if (i_cmd.out_load) r_res <= out_sum[SAMPLE_BITS-1:0];
    end

    assign o_result = r_res;

endmodule

FILE: src/smcr_dp.sv
// Datapath: configuration registers, window control and the two channel lanes.
`include "stereo_median_click_repair_macros.svh"

module smcr_dp import smcr_pkg::*; #(
    parameter int MAX_WINDOW  = 9,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [FRAC_W-1:0]             i_cfg_data,
    input  t_cmd                          i_cmd,
    output t_stat                         o_stat,
    input  logic signed [SAMPLE_BITS-1:0] i_left,
    input  logic signed [SAMPLE_BITS-1:0] i_right,
    output logic signed [SAMPLE_BITS-1:0] o_left,
    output logic signed [SAMPLE_BITS-1:0] o_right
);

    localparam int    POS_W    = $clog2(MAX_WINDOW + 1);
    localparam int    IDX_W    = $clog2(MAX_WINDOW);
    localparam int    LW       = SAMPLE_BITS + 17;
    localparam longint HALF    = longint'(1) << (SAMPLE_BITS - 1);
    localparam longint DEV_BASE = (HALF * 5) / 1000;
    localparam longint DEV_SPAN = (HALF * 95) / 1000;

    t_cfg                   r_cfg;
    logic [POS_W-1:0]       r_wp;
    logic [IDX_W-1:0]       r_cand;
    logic [SAMPLE_BITS-1:0] r_limit;

    logic [4:0]             win_odd;
    logic [POS_W-1:0]       win;
    logic [FRAC_W-1:0]      knob;
    logic [FRAC_W-1:0]      rep;
    logic [FRAC_W-1:0]      mix;
    logic [LW-1:0]          span_prod;
    logic [LW-1:0]          lim_sum;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_knob <= RST_THRESHOLD;
            r_cfg.repair_amount  <= RST_REPAIR;
            r_cfg.window_length  <= RST_WINDOW;
            r_cfg.wet_mix        <= RST_MIX;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_THRESHOLD: r_cfg.threshold_knob <= i_cfg_data;
                CFG_REPAIR:    r_cfg.repair_amount  <= i_cfg_data;
                CFG_WINDOW:    r_cfg.window_length  <= i_cfg_data[WIN_REG_W-1:0];
                CFG_MIX:       r_cfg.wet_mix        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Fractions above one act as one
    assign knob = r_cfg.threshold_knob[FRAC_W-1] ? FRAC_ONE : r_cfg.threshold_knob;
    assign rep  = r_cfg.repair_amount[FRAC_W-1]  ? FRAC_ONE : r_cfg.repair_amount;
    assign mix  = r_cfg.wet_mix[FRAC_W-1]        ? FRAC_ONE : r_cfg.wet_mix;

    // Window: odd, clamped to 3..MAX_WINDOW
    assign win_odd = {1'b0, r_cfg.window_length | 4'd1};
    always_comb begin
        if (win_odd < 5'd3) begin
            win = POS_W'(3);
        end else if (win_odd > 5'(MAX_WINDOW)) begin
            win = POS_W'(MAX_WINDOW);
        end else begin
            win = POS_W'(win_odd);
        end
    end

    // Deviation limit, refreshed every cycle from the threshold knob
    assign span_prod = LW'(DEV_SPAN) * LW'(knob);
    assign lim_sum   = LW'(DEV_BASE) + (span_prod >> 16);
    always_ff @(posedge i_clk) begin
        r_limit <= lim_sum[SAMPLE_BITS-1:0];
    end

    // Write position: step on transfer, then fold below the window while busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else if (i_cmd.load_in) begin
            if (r_wp < POS_W'(MAX_WINDOW)) begin
                r_wp <= r_wp + POS_W'(1);
            end else begin
                r_wp <= '0;
            end
        end else if (i_cmd.busy && (r_wp >= win)) begin
            r_wp <= r_wp - win;
        end
    end

    // Median candidate counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= '0;
        end else if (i_cmd.load_in) begin
            r_cand <= '0;
        end else if (i_cmd.scan) begin
            r_cand <= r_cand + IDX_W'(1);
        end
    end

    assign o_stat.scan_last = (POS_W'(r_cand) == (win - POS_W'(1)));

    smcr_lane #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .POS_W       (POS_W),
        .IDX_W       (IDX_W)
    ) u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_sample (i_left),
        .i_wr_pos (r_wp),
        .i_cand   (r_cand),
        .i_win    (win),
        .i_limit  (r_limit),
        .i_rep    (rep),
        .i_mix    (mix),
        .o_result (o_left)
    );

    smcr_lane #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .POS_W       (POS_W),
        .IDX_W       (IDX_W)
    ) u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_sample (i_right),
        .i_wr_pos (r_wp),
        .i_cand   (r_cand),
        .i_win    (win),
        .i_limit  (r_limit),
        .i_rep    (rep),
        .i_mix    (mix),
        .o_result (o_right)
    );

    `SMCR_ASSERT(a_cand_in_window, i_clk, i_rst_n, i_cmd.scan |-> (POS_W'(r_cand) < win), "median candidate outside window")
    `SMCR_ASSERT(a_pos_folded, i_clk, i_rst_n, i_cmd.out_load |=> (r_wp < win), "write position not folded into window at item end")

endmodule

FILE: src/stereo_median_click_repair.sv
// Steps: SCAN over W candidates, REP, MIX, DONE; W = odd clamped window (3..MAX_WINDOW).
// A new stereo pair is accepted only once the previous one has left DONE for idle.
// The median scan tests one window entry per cycle against all others, so W sets the rate.
// A finished result waits in the output register while the next pair is accepted.
// Reset (i_rst_n low, synchronous) clears both histories, the write position
// and the control state, and returns the configuration registers to their defaults.
module stereo_median_click_repair import smcr_pkg::*; #(
    parameter int MAX_WINDOW  = 9,
    parameter int SAMPLE_BITS = 24,
    localparam int TDATA_W    = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_W-1:0]    s_axis_tdata,  // left_sample, right_sample, zero pad
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata,  // left_result, right_result, zero pad
    // Configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [FRAC_W-1:0]     i_cfg_data
);

    t_cmd                          cmd;
    t_stat                         stat;
    logic signed [SAMPLE_BITS-1:0] left_result;
    logic signed [SAMPLE_BITS-1:0] right_result;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

    smcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    smcr_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_left      (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_right     (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .o_left      (left_result),
        .o_right     (right_result)
    );

    // Pack results, zero padded to whole bytes
    assign m_axis_tdata = TDATA_W'({right_result, left_result});

endmodule
